### rtl/core/bank_pkg.sv
`default_nettype none

package bank_pkg;

   localparam int PROCESSES = 8;
   localparam int RESOURCES = 4;

   localparam int PIDX_W = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
   localparam int RIDX_W = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
   localparam int CNT_W  = $clog2(PROCESSES + 1);
   // work vector holds available plus every allocation
   localparam int WORK_W = 8 + $clog2(PROCESSES + 1);

   localparam int OPC_W  = 2;
   localparam int PIN_W  = 3;
   localparam int RIN_W  = 2;
   localparam int AMT_W  = 8;
   localparam int STAT_W = 3;

   localparam logic [OPC_W-1:0] OP_CLAIM   = 2'd0;
   localparam logic [OPC_W-1:0] OP_AVAIL   = 2'd1;
   localparam logic [OPC_W-1:0] OP_REQUEST = 2'd2;

   localparam logic [STAT_W-1:0] ST_TAKEN   = 3'd0;
   localparam logic [STAT_W-1:0] ST_GRANTED = 3'd1;
   localparam logic [STAT_W-1:0] ST_NEED    = 3'd2;
   localparam logic [STAT_W-1:0] ST_AVAIL   = 3'd3;
   localparam logic [STAT_W-1:0] ST_UNSAFE  = 3'd4;

   typedef logic [AMT_W-1:0] amount_type;
   typedef amount_type [RESOURCES-1:0] row_type;

   typedef struct packed {
      logic take_item;
      logic decide;
      logic scan_step;
      logic rollback;
      logic emit;
      logic clear_request;
   } bank_cmd_type;

   typedef struct packed {
      logic out_free;
      logic item_final;
      logic deny;
      logic scan_done;
      logic scan_safe;
      logic emit_last;
   } bank_stat_type;

endpackage

`default_nettype wire

### rtl/core/bank_chan_if.sv
`default_nettype none

interface bank_req_if import bank_pkg::*;;
   logic               valid;
   logic               ready;
   logic [OPC_W-1:0]   opcode;
   logic [PIN_W-1:0]   process_index;
   logic [RIN_W-1:0]   resource_index;
   logic [AMT_W-1:0]   amount;
   logic               final_element;

   modport source (output valid, opcode, process_index, resource_index, amount, final_element,
                   input ready);
   modport sink (input valid, opcode, process_index, resource_index, amount, final_element,
                 output ready);
endinterface

interface bank_rsp_if import bank_pkg::*;;
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [PIN_W-1:0]   safe_process;
   logic               end_of_run;

   modport source (output valid, status, safe_process, end_of_run, input ready);
   modport sink (input valid, status, safe_process, end_of_run, output ready);
endinterface

`default_nettype wire

### rtl/core/bankers_resource_grant.sv
// Banker's algorithm grant unit.
// req_bus carries claim loads, available-count writes and request elements;
// rsp_bus returns results. Both are valid/ready channels.
// Claim, available and non-final request transactions give one result with
// status taken, registered in the cycle after acceptance.
// A final request element starts the decision: a need/available compare in
// the decide state, then a safety scan that tests one process per cycle
// against the work vector. The scan takes at most PROCESSES*PROCESSES steps
// (64 for eight processes); the scan state then sees it end. A denied request
// gives one result; an unsafe one gives it with the rollback; a granted one
// gives PROCESSES results in safe order, one per cycle while rsp_bus does not
// stall, with end_of_run on the last.
// A transaction is taken only while the output register is empty or its
// result leaves in that cycle, and never during a decision.
// A stall on rsp_bus holds the result and the block waits.
// Synchronous reset clears claims, allocations, available counts and the
// request buffer, and empties the output register.
`default_nettype none

module bankers_resource_grant import bank_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   bank_req_if.sink   req_bus,
   bank_rsp_if.source rsp_bus
);

   bank_cmd_type  cmd;
   bank_stat_type stat;

   bank_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bank_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .item_opcode         (req_bus.opcode),
      .item_process_index  (req_bus.process_index),
      .item_resource_index (req_bus.resource_index),
      .item_amount         (req_bus.amount),
      .item_final_element  (req_bus.final_element),
      .rsp_ready           (rsp_bus.ready),
      .rsp_valid           (rsp_bus.valid),
      .rsp_status          (rsp_bus.status),
      .rsp_safe_process    (rsp_bus.safe_process),
      .rsp_end_of_run      (rsp_bus.end_of_run)
   );

endmodule

`default_nettype wire

### rtl/core/bank_ctrl.sv
`default_nettype none

module bank_ctrl import bank_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  bank_stat_type stat,
   output bank_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECIDE = 5'b00010,
      S_SCAN   = 5'b00100,
      S_UNDO   = 5'b01000,
      S_EMIT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               cmd.take_item = 1'b1;
               if (stat.item_final) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            if (stat.out_free) begin
               cmd.decide = 1'b1;
               if (stat.deny) begin
                  cmd.clear_request = 1'b1;
                  state_in          = S_IDLE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               if (stat.scan_safe) begin
                  cmd.clear_request = 1'b1;
                  state_in          = S_EMIT;
               end else begin
                  // request buffer still needed to undo the commit
                  state_in = S_UNDO;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_UNDO: begin
            if (stat.out_free) begin
               cmd.rollback      = 1'b1;
               cmd.clear_request = 1'b1;
               state_in          = S_IDLE;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/bank_dp.sv
`default_nettype none

module bank_dp import bank_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  bank_cmd_type       cmd,
   output bank_stat_type      stat,
   input  logic [OPC_W-1:0]   item_opcode,
   input  logic [PIN_W-1:0]   item_process_index,
   input  logic [RIN_W-1:0]   item_resource_index,
   input  logic [AMT_W-1:0]   item_amount,
   input  logic               item_final_element,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [PIN_W-1:0]   rsp_safe_process,
   output logic               rsp_end_of_run
);

   row_type                  avail_ff, avail_in;
   row_type                  req_buf_ff, req_buf_in;
   row_type                  need_ff [PROCESSES];
   row_type                  need_in [PROCESSES];
   row_type                  alloc_ff [PROCESSES];
   row_type                  alloc_in [PROCESSES];
   logic [PROCESSES-1:0]     finished_ff, finished_in;
   logic [PIDX_W-1:0]        order_ff [PROCESSES];
   logic [PIDX_W-1:0]        order_in [PROCESSES];
   logic [WORK_W-1:0]        work_ff [RESOURCES];
   logic [WORK_W-1:0]        work_in [RESOURCES];
   logic [PIDX_W-1:0]        scan_i_ff, scan_i_in;
   logic [CNT_W-1:0]         misses_ff, misses_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [PIDX_W-1:0]        emit_k_ff, emit_k_in;
   logic [PIDX_W-1:0]        p_ff, p_in;
   logic                     p_ok_ff, p_ok_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [PIN_W-1:0]         rsp_proc_ff, rsp_proc_in;
   logic                     rsp_end_ff, rsp_end_in;

   logic [PIDX_W-1:0]        item_p;
   logic [RIDX_W-1:0]        item_r;
   logic                     item_p_ok;
   logic                     item_r_ok;
   logic                     item_final;
   logic [PIDX_W-1:0]        row_sel;
   row_type                  need_row;
   row_type                  alloc_row;
   logic [STAT_W-1:0]        deny_code;
   logic                     fits;
   logic                     out_free;
   logic                     emit_last;

   assign item_p     = PIDX_W'(item_process_index);
   assign item_r     = RIDX_W'(item_resource_index);
   assign item_p_ok  = (int'(item_process_index) < PROCESSES);
   assign item_r_ok  = (int'(item_resource_index) < RESOURCES);
   assign item_final = (item_opcode == OP_REQUEST) && item_final_element;

   // one row port: scan reads the probed process, otherwise the requester
   assign row_sel   = cmd.scan_step ? scan_i_ff : p_ff;
   assign need_row  = need_ff[row_sel];
   assign alloc_row = alloc_ff[row_sel];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_last = (emit_k_ff == PIDX_W'(PROCESSES - 1));

   // first offending resource decides the denial code
   always_comb begin
      deny_code = ST_GRANTED;
      if (!p_ok_ff) begin
         deny_code = ST_NEED;
      end else begin
         for (int k = 0; k < RESOURCES; k++) begin
            if (deny_code == ST_GRANTED) begin
               if (req_buf_ff[k] > need_row[k]) begin
                  deny_code = ST_NEED;
               end else if (req_buf_ff[k] > avail_ff[k]) begin
                  deny_code = ST_AVAIL;
               end
            end
         end
      end
   end

   // all resources of the probed process must fit together
   always_comb begin
      fits = !finished_ff[scan_i_ff];
      for (int r = 0; r < RESOURCES; r++) begin
         if (WORK_W'(need_row[r]) > work_ff[r]) begin
            fits = 1'b0;
         end
      end
   end

   always_comb begin
      stat.out_free   = out_free;
      stat.item_final = item_final;
      stat.deny       = (deny_code != ST_GRANTED);
      stat.scan_done  = (count_ff == CNT_W'(PROCESSES)) || (misses_ff == CNT_W'(PROCESSES));
      stat.scan_safe  = (count_ff == CNT_W'(PROCESSES));
      stat.emit_last  = emit_last;
   end

   always_comb begin
      avail_in      = avail_ff;
      req_buf_in    = req_buf_ff;
      need_in       = need_ff;
      alloc_in      = alloc_ff;
      finished_in   = finished_ff;
      order_in      = order_ff;
      work_in       = work_ff;
      scan_i_in     = scan_i_ff;
      misses_in     = misses_ff;
      count_in      = count_ff;
      emit_k_in     = emit_k_ff;
      p_in          = p_ff;
      p_ok_in       = p_ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_proc_in   = rsp_proc_ff;
      rsp_end_in    = rsp_end_ff;

      if (cmd.take_item) begin
         case (item_opcode)
            OP_CLAIM: begin
               if (item_p_ok && item_r_ok) begin
                  need_in[item_p][item_r]  = item_amount;
                  alloc_in[item_p][item_r] = '0;
               end
            end
            OP_AVAIL: begin
               if (item_r_ok) begin
                  avail_in[item_r] = item_amount;
               end
            end
            OP_REQUEST: begin
               if (item_p_ok && item_r_ok) begin
                  req_buf_in[item_r] = item_amount;
               end
               if (item_final_element) begin
                  p_in    = item_p;
                  p_ok_in = item_p_ok;
               end
            end
            default: begin
            end
         endcase
         if (!item_final) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_TAKEN;
            rsp_proc_in   = '0;
            rsp_end_in    = 1'b1;
         end
      end

      if (cmd.decide) begin
         if (deny_code != ST_GRANTED) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = deny_code;
            rsp_proc_in   = '0;
            rsp_end_in    = 1'b1;
         end else begin
            for (int r = 0; r < RESOURCES; r++) begin
               avail_in[r]       = avail_ff[r] - req_buf_ff[r];
               alloc_in[p_ff][r] = alloc_row[r] + req_buf_ff[r];
               need_in[p_ff][r]  = need_row[r] - req_buf_ff[r];
               work_in[r]        = WORK_W'(avail_ff[r] - req_buf_ff[r]);
            end
            finished_in = '0;
            scan_i_in   = p_ff;
            misses_in   = '0;
            count_in    = '0;
            emit_k_in   = '0;
         end
      end

      if (cmd.scan_step) begin
         if (fits) begin
            for (int r = 0; r < RESOURCES; r++) begin
               work_in[r] = work_ff[r] + WORK_W'(alloc_row[r]);
            end
            finished_in[scan_i_ff]          = 1'b1;
            order_in[count_ff[PIDX_W-1:0]]  = scan_i_ff;
            count_in                        = count_ff + 1'b1;
            misses_in                       = '0;
            scan_i_in                       = '0;
         end else begin
            misses_in = misses_ff + 1'b1;
            scan_i_in = (scan_i_ff == PIDX_W'(PROCESSES - 1)) ? '0 : scan_i_ff + 1'b1;
         end
      end

      if (cmd.rollback) begin
         for (int r = 0; r < RESOURCES; r++) begin
            avail_in[r]       = avail_ff[r] + req_buf_ff[r];
            alloc_in[p_ff][r] = alloc_row[r] - req_buf_ff[r];
            need_in[p_ff][r]  = need_row[r] + req_buf_ff[r];
         end
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_UNSAFE;
         rsp_proc_in   = '0;
         rsp_end_in    = 1'b1;
      end

      if (cmd.clear_request) begin
         req_buf_in = '0;
      end

      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_GRANTED;
         rsp_proc_in   = PIN_W'(order_ff[emit_k_ff]);
         rsp_end_in    = emit_last;
         emit_k_in     = emit_last ? '0 : emit_k_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff     <= '0;
         req_buf_ff   <= '0;
         finished_ff  <= '0;
         scan_i_ff    <= '0;
         misses_ff    <= '0;
         count_ff     <= '0;
         emit_k_ff    <= '0;
         p_ff         <= '0;
         p_ok_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PROCESSES; i++) begin
            need_ff[i]  <= '0;
            alloc_ff[i] <= '0;
         end
      end else begin
         avail_ff     <= avail_in;
         req_buf_ff   <= req_buf_in;
         finished_ff  <= finished_in;
         scan_i_ff    <= scan_i_in;
         misses_ff    <= misses_in;
         count_ff     <= count_in;
         emit_k_ff    <= emit_k_in;
         p_ff         <= p_in;
         p_ok_ff      <= p_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         need_ff      <= need_in;
         alloc_ff     <= alloc_in;
      end
   end

   always_ff @(posedge clock) begin
      order_ff      <= order_in;
      work_ff       <= work_in;
      rsp_status_ff <= rsp_status_in;
      rsp_proc_ff   <= rsp_proc_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_safe_process = rsp_proc_ff;
   assign rsp_end_of_run   = rsp_end_ff;

endmodule

`default_nettype wire

### rtl/core/bank_checker.sv
`default_nettype none

module bank_checker import bank_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic [OPC_W-1:0]  req_opcode,
   input wire logic              req_final_element,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [STAT_W-1:0] rsp_status,
   input wire logic [PIN_W-1:0]  rsp_safe_process,
   input wire logic              rsp_end_of_run
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_safe_process) && $stable(rsp_end_of_run))
      else $error("result changed while stalled");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_GRANTED |-> rsp_end_of_run && rsp_safe_process == '0)
      else $error("non-grant result not a single closing result");

   a_decide_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == OP_REQUEST && req_final_element |=> !req_ready)
      else $error("transaction taken while a decision starts");

   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_GRANTED && !rsp_end_of_run |-> !req_ready)
      else $error("transaction taken in the middle of a safe sequence");

endmodule

bind bankers_resource_grant bank_checker u_bank_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .req_opcode        (req_bus.opcode),
   .req_final_element (req_bus.final_element),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_status        (rsp_bus.status),
   .rsp_safe_process  (rsp_bus.safe_process),
   .rsp_end_of_run    (rsp_bus.end_of_run)
);

`default_nettype wire
